### hdl/osi_pkg.sv
// Package with the constants, register indexes and address permutations of the symbol interleaver.
package osi_pkg;

  localparam int unsigned CNT_W  = 14;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned LFSR_W = 12;

  localparam logic [CNT_W-1:0] MODE_2K_SIZE = 14'd2048;
  localparam logic [CNT_W-1:0] MODE_8K_SIZE = 14'd8192;

  localparam logic CFG_MODE_8K = 1'b0;
  localparam logic CFG_USABLE  = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  function automatic logic [ADDR_W-1:0] permute_2k(input logic [LFSR_W-1:0] s, input logic i0);
    logic [ADDR_W-1:0] a;
    a     = '0;
    a[4]  = s[0];
    a[3]  = s[1];
    a[9]  = s[2];
    a[6]  = s[3];
    a[2]  = s[4];
    a[8]  = s[5];
    a[1]  = s[6];
    a[5]  = s[7];
    a[7]  = s[8];
    a[0]  = s[9];
    a[10] = i0;
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] permute_8k(input logic [LFSR_W-1:0] s, input logic i0);
    logic [ADDR_W-1:0] a;
    a     = '0;
    a[7]  = s[0];
    a[1]  = s[1];
    a[4]  = s[2];
    a[2]  = s[3];
    a[9]  = s[4];
    a[6]  = s[5];
    a[8]  = s[6];
    a[10] = s[7];
    a[0]  = s[8];
    a[3]  = s[9];
    a[11] = s[10];
    a[5]  = s[11];
    a[12] = i0;
    return a;
  endfunction

endpackage

### hdl/ofdm_symbol_interleaver_unit.sv
// Top level of the 2k/8k OFDM symbol interleaver with an LFSR address generator.
// An accepted word goes through GEN, where k (at least 1) is the number of generator steps to
// the next address below the symbol length, one per cycle, then ACCESS, then OUT while a
// symbol is held. No new word is taken until the unit is back in IDLE; a result that still
// waits to be taken holds the next one back. k averages under two near the full mode size.
// Reset is asynchronous, active low, sets 2k mode and 1512 carriers, drops any held symbol.
module ofdm_symbol_interleaver_unit
  import osi_pkg::*;
#(
  parameter int unsigned MAX_CARRIERS = 8192,
  parameter int unsigned WORD_BITS    = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 symbol_is_odd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] word_out_o,
  output logic                 last_of_symbol_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i
);

  localparam int unsigned POS_AW = $clog2(MAX_CARRIERS);
  localparam int unsigned MEM_AW = $clog2(2 * MAX_CARRIERS);
  localparam logic [CNT_W-1:0]  MAX_N    = CNT_W'(MAX_CARRIERS);
  localparam logic [MEM_AW-1:0] BANK_OFS = MEM_AW'(MAX_CARRIERS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GEN    = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]           state_q, state_d;
  logic                 mode_8k_q, mode_8k_d;
  logic [CNT_W-1:0]     usable_q, usable_d;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic [CNT_W-1:0]     raw_q, raw_d;
  logic [CNT_W-1:0]     position_q, position_d;
  logic                 write_bank_q, write_bank_d;
  logic                 held_valid_q, held_valid_d;
  logic                 held_odd_q, held_odd_d;
  logic                 cur_odd_q, cur_odd_d;
  logic                 drained_q, drained_d;
  logic                 cmd_q, cmd_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [ADDR_W-1:0]    h_q, h_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] out_word_q, out_word_d;
  logic                 out_last_q, out_last_d;

  logic [WORD_BITS-1:0] mem [2*MAX_CARRIERS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [MEM_AW-1:0]    waddr, raddr;
  logic [POS_AW-1:0]    widx, ridx;

  logic [CNT_W-1:0]     mode_size, len_n, len_a, len_b;
  logic [LFSR_W-1:0]    gen_s;
  logic [ADDR_W-1:0]    gen_a;
  logic                 fb;
  logic [CNT_W-1:0]     pos_eff;
  logic                 restart;

  always_comb begin
    mode_size = mode_8k_q ? MODE_8K_SIZE : MODE_2K_SIZE;
    len_a     = (usable_q == '0) ? CNT_W'(1) : usable_q;
    len_b     = (len_a > mode_size) ? mode_size : len_a;
    len_n     = (len_b > MAX_N) ? MAX_N : len_b;
  end

  always_comb begin
    fb = 1'b0;
    if (raw_q < CNT_W'(2)) begin
      gen_s = '0;
    end else if (raw_q == CNT_W'(2)) begin
      gen_s = LFSR_W'(1);
    end else if (mode_8k_q) begin
      fb    = lfsr_q[0] ^ lfsr_q[1] ^ lfsr_q[4] ^ lfsr_q[6];
      gen_s = {fb, lfsr_q[LFSR_W-1:1]};
    end else begin
      fb    = lfsr_q[0] ^ lfsr_q[3];
      gen_s = {2'b00, fb, lfsr_q[9:1]};
    end
    gen_a = mode_8k_q ? permute_8k(gen_s, raw_q[0]) : permute_2k(gen_s, raw_q[0]);
  end

  assign pos_eff = (position_q >= len_n) ? '0 : position_q;
  assign restart = position_q >= len_n;

  always_comb begin
    state_d      = state_q;
    mode_8k_d    = mode_8k_q;
    usable_d     = usable_q;
    lfsr_d       = lfsr_q;
    raw_d        = raw_q;
    position_d   = position_q;
    write_bank_d = write_bank_q;
    held_valid_d = held_valid_q;
    held_odd_d   = held_odd_q;
    cur_odd_d    = cur_odd_q;
    drained_d    = drained_q;
    cmd_d        = cmd_q;
    word_d       = word_q;
    h_d          = h_q;
    last_d       = last_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    widx         = cur_odd_q ? position_q[POS_AW-1:0] : h_q[POS_AW-1:0];
    ridx         = held_odd_q ? h_q[POS_AW-1:0] : position_q[POS_AW-1:0];
    waddr        = write_bank_q ? (BANK_OFS + MEM_AW'(widx)) : MEM_AW'(widx);
    raddr        = write_bank_q ? MEM_AW'(ridx) : (BANK_OFS + MEM_AW'(ridx));

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          word_d     = word_i;
          position_d = pos_eff;
          if (restart) begin
            lfsr_d    = '0;
            raw_d     = '0;
            drained_d = 1'b0;
          end
          if (pos_eff == '0) begin
            cur_odd_d = symbol_is_odd_i;
            drained_d = 1'b0;
          end
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (raw_q >= mode_size) begin
          h_d     = '0;
          state_d = ST_ACCESS;
        end else begin
          lfsr_d = gen_s;
          raw_d  = raw_q + CNT_W'(1);
          if (CNT_W'(gen_a) < len_n) begin
            h_d     = gen_a;
            state_d = ST_ACCESS;
          end else if (raw_d == mode_size) begin
            h_d     = '0;
            state_d = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        mem_we = (cmd_q == CMD_WRITE);
        mem_re = held_valid_q;
        last_d = (position_q + CNT_W'(1)) == len_n;
        if ((position_q + CNT_W'(1)) >= len_n) begin
          held_valid_d = !(drained_q || (cmd_q == CMD_DRAIN));
          held_odd_d   = cur_odd_q;
          write_bank_d = !write_bank_q;
          lfsr_d       = '0;
          raw_d        = '0;
          position_d   = '0;
          drained_d    = 1'b0;
        end else begin
          position_d = position_q + CNT_W'(1);
          drained_d  = drained_q || (cmd_q == CMD_DRAIN);
        end
        state_d = held_valid_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = rdata_q;
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE_8K: mode_8k_d = cfg_wdata_i[0];
        CFG_USABLE:  usable_d  = cfg_wdata_i;
        default:     mode_8k_d = mode_8k_q;
      endcase
      lfsr_d       = '0;
      raw_d        = '0;
      position_d   = '0;
      drained_d    = 1'b0;
      held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= word_q;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_8k_q    <= 1'b0;
      usable_q     <= CNT_W'(1512);
      lfsr_q       <= '0;
      raw_q        <= '0;
      position_q   <= '0;
      write_bank_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_odd_q   <= 1'b0;
      cur_odd_q    <= 1'b0;
      drained_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_8k_q    <= mode_8k_d;
      usable_q     <= usable_d;
      lfsr_q       <= lfsr_d;
      raw_q        <= raw_d;
      position_q   <= position_d;
      write_bank_q <= write_bank_d;
      held_valid_q <= held_valid_d;
      held_odd_q   <= held_odd_d;
      cur_odd_q    <= cur_odd_d;
      drained_q    <= drained_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    word_q     <= word_d;
    h_q        <= h_d;
    last_q     <= last_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign word_out_o       = out_word_q;
  assign last_of_symbol_o = out_last_q;

endmodule

### hdl/osi_checker.sv
// Port-level checker for the symbol interleaver and its bind to the top level.
module osi_checker #(
  parameter int unsigned WORD_BITS = 6
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_BITS-1:0] word_out_o,
  input logic                 last_of_symbol_o
);

  a_out_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_out_payload_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(word_out_o) && $stable(last_of_symbol_o))
    else $error("Output word changed while stalled.");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not held off after a word was accepted.");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Output word appeared without an item in progress.");

endmodule

bind ofdm_symbol_interleaver_unit osi_checker #(.WORD_BITS(WORD_BITS)) u_osi_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .word_out_o       (word_out_o),
  .last_of_symbol_o (last_of_symbol_o)
);
